>>> hw/rtl/bcc_pkg.sv
// Shared types and constants of the button click classifier.
`default_nettype none

package bcc_pkg;

   localparam int KIND_W     = 3;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int MASK_W     = 2;
   localparam int DEB_W      = 8;
   localparam int CNT_W      = 16;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [KIND_W-1:0] {
      EV_SHORT    = 3'd0,
      EV_LONG     = 3'd1,
      EV_DOUBLE   = 3'd2,
      EV_REPEAT   = 3'd3,
      EV_RELEASED = 3'd4
   } ev_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CONT_MASK    = 3'd0,
      CSR_DBL_MASK     = 3'd1,
      CSR_DEBOUNCE     = 3'd2,
      CSR_LONG_PRESS   = 3'd3,
      CSR_DBL_GAP      = 3'd4,
      CSR_REPEAT_START = 3'd5,
      CSR_REPEAT_INTV  = 3'd6
   } csr_reg_type;

   localparam logic [MASK_W-1:0] CONT_MASK_RST    = 2'd0;
   localparam logic [MASK_W-1:0] DBL_MASK_RST     = 2'd0;
   localparam logic [DEB_W-1:0]  DEBOUNCE_RST     = 8'd5;
   localparam logic [CNT_W-1:0]  LONG_PRESS_RST   = 16'd500;
   localparam logic [CNT_W-1:0]  DBL_GAP_RST      = 16'd50;
   localparam logic [CNT_W-1:0]  REPEAT_START_RST = 16'd250;
   localparam logic [CNT_W-1:0]  REPEAT_INTV_RST  = 16'd20;

   typedef struct packed {
      logic [MASK_W-1:0] cont_mask;
      logic [MASK_W-1:0] dbl_mask;
      logic [DEB_W-1:0]  debounce;
      logic [CNT_W-1:0]  long_press;
      logic [CNT_W-1:0]  dbl_gap;
      logic [CNT_W-1:0]  repeat_start;
      logic [CNT_W-1:0]  repeat_intv;
   } cfg_type;

endpackage

`default_nettype wire

>>> hw/rtl/bcc_csr.sv
// Configuration register file of the button click classifier.
`default_nettype none

module bcc_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             wr_en,
   input  wire logic [bcc_pkg::CSR_IDX_W-1:0]    wr_index,
   input  wire logic [bcc_pkg::CSR_DATA_W-1:0]   wr_data,
   output bcc_pkg::cfg_type                      cfg
);

   bcc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            bcc_pkg::CSR_CONT_MASK:    cfg_in.cont_mask    = wr_data[bcc_pkg::MASK_W-1:0];
            bcc_pkg::CSR_DBL_MASK:     cfg_in.dbl_mask     = wr_data[bcc_pkg::MASK_W-1:0];
            bcc_pkg::CSR_DEBOUNCE:     cfg_in.debounce     = wr_data[bcc_pkg::DEB_W-1:0];
            bcc_pkg::CSR_LONG_PRESS:   cfg_in.long_press   = wr_data[bcc_pkg::CNT_W-1:0];
            bcc_pkg::CSR_DBL_GAP:      cfg_in.dbl_gap      = wr_data[bcc_pkg::CNT_W-1:0];
            bcc_pkg::CSR_REPEAT_START: cfg_in.repeat_start = wr_data[bcc_pkg::CNT_W-1:0];
            bcc_pkg::CSR_REPEAT_INTV:  cfg_in.repeat_intv  = wr_data[bcc_pkg::CNT_W-1:0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cont_mask    <= bcc_pkg::CONT_MASK_RST;
         cfg_ff.dbl_mask     <= bcc_pkg::DBL_MASK_RST;
         cfg_ff.debounce     <= bcc_pkg::DEBOUNCE_RST;
         cfg_ff.long_press   <= bcc_pkg::LONG_PRESS_RST;
         cfg_ff.dbl_gap      <= bcc_pkg::DBL_GAP_RST;
         cfg_ff.repeat_start <= bcc_pkg::REPEAT_START_RST;
         cfg_ff.repeat_intv  <= bcc_pkg::REPEAT_INTV_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> hw/rtl/bcc_front.sv
// Front end: per-button debounce and click classification, one tick per cycle while ticks are accepted.
`default_nettype none

module bcc_front #(
   parameter int NUM_BUTTONS = 2
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  bcc_pkg::cfg_type                             cfg,
   input  wire logic [NUM_BUTTONS-1:0]                  raw_levels,
   input  wire logic                                    accept,
   output logic                                         rec_push,
   output logic [NUM_BUTTONS-1:0]                       rec_valid,
   output logic [NUM_BUTTONS*bcc_pkg::KIND_W-1:0]       rec_kinds
);

   localparam int KW = bcc_pkg::KIND_W;
   localparam int DW = bcc_pkg::DEB_W;
   localparam int CW = bcc_pkg::CNT_W;
   localparam int MW = bcc_pkg::MASK_W;

   logic [NUM_BUTTONS-1:0] level_ff, level_in;
   logic [NUM_BUTTONS-1:0] long_ff, long_in;
   logic [NUM_BUTTONS-1:0] pend_ff, pend_in;
   logic [DW-1:0]          mism_ff  [NUM_BUTTONS];
   logic [DW-1:0]          mism_in  [NUM_BUTTONS];
   logic [CW-1:0]          held_ff  [NUM_BUTTONS];
   logic [CW-1:0]          held_in  [NUM_BUTTONS];
   logic [CW-1:0]          gap_ff   [NUM_BUTTONS];
   logic [CW-1:0]          gap_in   [NUM_BUTTONS];
   logic [CW-1:0]          phase_ff [NUM_BUTTONS];
   logic [CW-1:0]          phase_in [NUM_BUTTONS];

   logic [NUM_BUTTONS+MW-1:0] cont_ext, dbl_ext;

   assign cont_ext = {{NUM_BUTTONS{1'b0}}, cfg.cont_mask};
   assign dbl_ext  = {{NUM_BUTTONS{1'b0}}, cfg.dbl_mask};

   always_comb begin
      logic [DW:0]   mnext;
      logic [CW:0]   pnext;
      logic [CW-1:0] limit;
      logic          few_down;
      logic          rose;
      logic          cont;
      logic          dbl;

      level_in  = level_ff;
      long_in   = long_ff;
      pend_in   = pend_ff;
      rec_valid = '0;
      rec_kinds = '0;

      // debounce: cumulative mismatch count, adopt raw level once exceeded
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         mism_in[b] = mism_ff[b];
         mnext      = {1'b0, mism_ff[b]} + 1'b1;
         if (raw_levels[b] != level_ff[b]) begin
            if (mnext > {1'b0, cfg.debounce}) begin
               level_in[b] = raw_levels[b];
               mism_in[b]  = '0;
            end else begin
               mism_in[b]  = mnext[DW-1:0];
            end
         end
      end

      few_down = (level_in & (level_in - 1'b1)) == '0;

      for (int b = 0; b < NUM_BUTTONS; b++) begin
         cont        = cont_ext[b];
         dbl         = dbl_ext[b];
         held_in[b]  = held_ff[b];
         gap_in[b]   = gap_ff[b];
         phase_in[b] = phase_ff[b];
         rose        = 1'b0;
         pnext       = {1'b0, phase_ff[b]} + 1'b1;
         limit       = cont ? cfg.repeat_start : cfg.long_press;
         if (level_in[b]) begin
            gap_in[b] = '0;
            if (!long_ff[b] && held_ff[b] != bcc_pkg::CNT_MAX) begin
               held_in[b] = held_ff[b] + 1'b1;
               rose       = 1'b1;
               if (held_in[b] > cfg.repeat_start) begin
                  // phase wraps at the interval; zero interval acts as one
                  if (pnext >= {1'b0, cfg.repeat_intv}) begin
                     phase_in[b] = '0;
                  end else begin
                     phase_in[b] = pnext[CW-1:0];
                  end
               end
            end
            if (few_down) begin
               if (cont) begin
                  if (rose && held_in[b] > cfg.repeat_start && phase_in[b] == '0) begin
                     rec_valid[b]            = 1'b1;
                     rec_kinds[b*KW +: KW]   = bcc_pkg::EV_REPEAT;
                  end
               end else if (!long_ff[b] && held_in[b] > cfg.long_press) begin
                  long_in[b]              = 1'b1;
                  rec_valid[b]            = 1'b1;
                  rec_kinds[b*KW +: KW]   = bcc_pkg::EV_LONG;
               end
            end
         end else begin
            if (!long_ff[b]) begin
               if (held_ff[b] != '0 && held_ff[b] < limit) begin
                  if (dbl) begin
                     if (!pend_ff[b]) begin
                        pend_in[b] = 1'b1;
                     end else begin
                        pend_in[b]            = 1'b0;
                        rec_valid[b]          = 1'b1;
                        rec_kinds[b*KW +: KW] = bcc_pkg::EV_DOUBLE;
                     end
                  end else begin
                     rec_valid[b]          = 1'b1;
                     rec_kinds[b*KW +: KW] = bcc_pkg::EV_SHORT;
                  end
               end else if (held_ff[b] == '0) begin
                  if (pend_ff[b]) begin
                     if (gap_ff[b] != bcc_pkg::CNT_MAX) begin
                        gap_in[b] = gap_ff[b] + 1'b1;
                     end
                     if (gap_in[b] > cfg.dbl_gap) begin
                        pend_in[b]            = 1'b0;
                        rec_valid[b]          = 1'b1;
                        rec_kinds[b*KW +: KW] = bcc_pkg::EV_SHORT;
                     end
                  end
               end else if (cont && held_ff[b] > cfg.repeat_start) begin
                  rec_valid[b]          = 1'b1;
                  rec_kinds[b*KW +: KW] = bcc_pkg::EV_RELEASED;
               end
            end
            held_in[b]  = '0;
            long_in[b]  = 1'b0;
            phase_in[b] = '0;
         end
      end
   end

   assign rec_push = accept && (rec_valid != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff <= '0;
         long_ff  <= '0;
         pend_ff  <= '0;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            mism_ff[b]  <= '0;
            held_ff[b]  <= '0;
            gap_ff[b]   <= '0;
            phase_ff[b] <= '0;
         end
      end else if (accept) begin
         level_ff <= level_in;
         long_ff  <= long_in;
         pend_ff  <= pend_in;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            mism_ff[b]  <= mism_in[b];
            held_ff[b]  <= held_in[b];
            gap_ff[b]   <= gap_in[b];
            phase_ff[b] <= phase_in[b];
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/bcc_fifo.sv
// Small queue of per-tick event records between front and back end.
`default_nettype none

module bcc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      head_data,
   output logic                  full,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign head_data = mem[rd_ptr_ff];

endmodule

`default_nettype wire

>>> hw/rtl/bcc_back.sv
// Back end: splits a tick record into single events in button order.
`default_nettype none

module bcc_back #(
   parameter int NUM_BUTTONS = 2
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 head_valid,
   input  wire logic [NUM_BUTTONS-1:0]               head_evs,
   input  wire logic [NUM_BUTTONS*bcc_pkg::KIND_W-1:0] head_kinds,
   output logic                                      head_pop,
   input  wire logic                                 rsp_pop,
   output logic                                      rsp_empty,
   output logic                                      rsp_button_id,
   output logic [bcc_pkg::KIND_W-1:0]                rsp_event_kind,
   output logic                                      rsp_last_of_tick
);

   localparam int KW = bcc_pkg::KIND_W;

   logic [NUM_BUTTONS-1:0] done_ff, done_in;
   logic [NUM_BUTTONS-1:0] remain, pick;
   logic                   out_valid_ff, out_valid_in;
   logic                   out_id_ff, out_id_in;
   logic [KW-1:0]          out_kind_ff, out_kind_in;
   logic                   out_last_ff, out_last_in;
   logic                   load, last;

   assign remain = head_evs & ~done_ff;
   assign pick   = remain & (~remain + 1'b1);
   assign last   = (remain & ~pick) == '0;
   assign load   = head_valid && (!out_valid_ff || rsp_pop);

   always_comb begin
      out_id_in   = out_id_ff;
      out_kind_in = out_kind_ff;
      out_last_in = out_last_ff;
      done_in     = done_ff;
      if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
      if (load) begin
         out_valid_in = 1'b1;
         out_last_in  = last;
         for (int b = 0; b < NUM_BUTTONS; b++) begin
            if (pick[b]) begin
               out_id_in   = 1'(b);
               out_kind_in = head_kinds[b*KW +: KW];
            end
         end
         // advance within the record, or drop it after its last event
         done_in = last ? '0 : (done_ff | pick);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         done_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      out_id_ff   <= out_id_in;
      out_kind_ff <= out_kind_in;
      out_last_ff <= out_last_in;
   end

   assign head_pop         = load && last;
   assign rsp_empty        = !out_valid_ff;
   assign rsp_button_id    = out_id_ff;
   assign rsp_event_kind   = out_kind_ff;
   assign rsp_last_of_tick = out_last_ff;

endmodule

`default_nettype wire

>>> hw/rtl/button_click_classifier.sv
// Top level of the button click classifier.
//
// Usage: push one scan tick of raw button levels per item on the req_ side
// (push/full). Each tick debounces every button and classifies it into at
// most one event per button: short, long, double, repeat or released.
// Events come out on the rsp_ side (empty/pop) one per item, in button
// order; rsp_last_of_tick marks the last event caused by a tick. Ticks that
// cause no event produce nothing.
// Throughput: one tick per cycle while req_full is low; the events of a tick
// leave one at a time through the single output register of the back end.
// Path: the record of an accepted tick is queued at the edge that accepts it,
// then its events load the output register of the back end in turn.
// When the receiver stalls, records wait in a QUEUE_DEPTH-entry queue;
// full rises once it holds that many ticks with events.
// Configuration: csr_ writes are always taken (csr_ready high) and must be
// done while the block is idle. Reset returns all registers to their
// defaults, clears all button state and empties the queue.
`default_nettype none

module button_click_classifier #(
   parameter int NUM_BUTTONS = 2,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_push,
   output logic                                  req_full,
   input  wire logic [NUM_BUTTONS-1:0]           req_raw_levels,
   output logic                                  rsp_empty,
   input  wire logic                             rsp_pop,
   output logic                                  rsp_button_id,
   output logic [bcc_pkg::KIND_W-1:0]            rsp_event_kind,
   output logic                                  rsp_last_of_tick,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [bcc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bcc_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int KIND_BITS = NUM_BUTTONS * bcc_pkg::KIND_W;
   localparam int REC_W     = NUM_BUTTONS + KIND_BITS;

   bcc_pkg::cfg_type       cfg;
   logic                   accept;
   logic                   rec_push, head_pop, q_empty;
   logic [NUM_BUTTONS-1:0] rec_valid;
   logic [KIND_BITS-1:0]   rec_kinds;
   logic [REC_W-1:0]       head_data;

   assign csr_ready = 1'b1;
   assign accept    = req_push && !req_full;

   bcc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   bcc_front #(.NUM_BUTTONS(NUM_BUTTONS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .raw_levels (req_raw_levels),
      .accept     (accept),
      .rec_push   (rec_push),
      .rec_valid  (rec_valid),
      .rec_kinds  (rec_kinds)
   );

   bcc_fifo #(.WIDTH(REC_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data ({rec_valid, rec_kinds}),
      .pop       (head_pop),
      .head_data (head_data),
      .full      (req_full),
      .empty     (q_empty)
   );

   bcc_back #(.NUM_BUTTONS(NUM_BUTTONS)) u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (!q_empty),
      .head_evs         (head_data[REC_W-1 -: NUM_BUTTONS]),
      .head_kinds       (head_data[KIND_BITS-1:0]),
      .head_pop         (head_pop),
      .rsp_pop          (rsp_pop),
      .rsp_empty        (rsp_empty),
      .rsp_button_id    (rsp_button_id),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_last_of_tick (rsp_last_of_tick)
   );

endmodule

`default_nettype wire

>>> hw/rtl/bcc_checker.sv
// Port-level checker of the button click classifier and its bind.
`default_nettype none

module bcc_checker #(
   parameter int NUM_BUTTONS = 2
) (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_push,
   input wire logic                           req_full,
   input wire logic [NUM_BUTTONS-1:0]         req_raw_levels,
   input wire logic                           rsp_empty,
   input wire logic                           rsp_pop,
   input wire logic                           rsp_button_id,
   input wire logic [bcc_pkg::KIND_W-1:0]     rsp_event_kind,
   input wire logic                           rsp_last_of_tick
);

   // a waiting event holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_button_id) && $stable(rsp_event_kind)
          && $stable(rsp_last_of_tick)))
      else $error("result changed while stalled");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_event_kind <= bcc_pkg::EV_RELEASED))
      else $error("event kind out of range");

   // events of one tick follow each other without a gap
   a_tick_burst: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_pop && !rsp_last_of_tick) |=> !rsp_empty)
      else $error("gap inside the events of one tick");

   a_levels_known: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |-> !$isunknown(req_raw_levels))
      else $error("unknown raw levels on an accepted item");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("not empty after reset");

endmodule

bind button_click_classifier bcc_checker #(.NUM_BUTTONS(NUM_BUTTONS)) u_bcc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_push         (req_push),
   .req_full         (req_full),
   .req_raw_levels   (req_raw_levels),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_button_id    (rsp_button_id),
   .rsp_event_kind   (rsp_event_kind),
   .rsp_last_of_tick (rsp_last_of_tick)
);

`default_nettype wire
